FILE: sv/fef_pkg.sv
// fef_pkg: shared types, constants and float32 arithmetic for fast_exp_float32
// holds the queue word type, status codes and round-to-nearest-even mul/add
// no dependencies
`default_nettype none

package fef_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // float32 bit patterns of the fixed constants
   localparam logic [31:0] LN2_BITS     = 32'h3F317218;
   localparam logic [31:0] INV_LN2_BITS = 32'h3FB8AA3B;
   localparam logic [31:0] PC4_BITS     = 32'h3D72AEBC;
   localparam logic [31:0] PC3_BITS     = 32'h3E1EDEB6;
   localparam logic [31:0] PC2_BITS     = 32'h3F00CA36;
   localparam logic [31:0] PC1_BITS     = 32'h3F7FEBA5;
   localparam logic [31:0] PC0_BITS     = 32'h3F80003D;

   localparam logic [31:0] QNAN_BITS    = 32'h7FC00000;
   localparam logic [30:0] INF_MAG      = 31'h7F800000;
   localparam logic [31:0] QUIET_BIT    = 32'h00400000;
   localparam logic [30:0] T_OVF_MAG    = 31'h43000000;  // 128.0
   localparam logic [30:0] T_UNF_MAG    = 31'h42FC0000;  // 126.0
   localparam int          EXP_BIAS     = 127;
   localparam int          MANT_BITS    = 23;

   typedef enum logic [1:0] {
      ST_NORMAL    = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_NAN       = 2'd3
   } fef_status_type;

   // one word between the front and the back
   typedef struct packed {
      logic [31:0]    y;        // x on entry, then the reduced argument
      logic [31:0]    p;        // k as float on entry, then k*ln2, then the polynomial
      logic [7:0]     e;        // biased exponent of 2^k
      fef_status_type st;
      logic           byp;      // result already known
      logic [31:0]    byp_val;
   } fef_item_type;

   function automatic logic [5:0] clz48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] clz27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      logic               sr;
      logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [23:0]        ma, mb;
      logic signed [10:0] ea_e, eb_e, er, tmp;
      logic [47:0]        prod, pn, shd, mask;
      logic [5:0]         lz, sh;
      logic               lost, g, s, inc;
      logic [23:0]        mant;
      logic [31:0]        base, sum, res;
      sr     = a[31] ^ b[31];
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      ma     = {a[30:23] != 8'd0, a[22:0]};
      mb     = {b[30:23] != 8'd0, b[22:0]};
      ea_e   = (a[30:23] == 8'd0) ? 11'sd1 : signed'({3'b0, a[30:23]});
      eb_e   = (b[30:23] == 8'd0) ? 11'sd1 : signed'({3'b0, b[30:23]});
      prod   = ma * mb;
      lz     = clz48(prod);
      pn     = prod << lz;
      er     = ea_e + eb_e - 11'sd126 - signed'({5'b0, lz});
      tmp    = 11'sd1 - er;
      if (er < 11'sd1) begin
         sh = (tmp > 11'sd49) ? 6'd49 : tmp[5:0];
      end else begin
         sh = 6'd0;
      end
      shd  = pn >> sh;
      mask = ~({48{1'b1}} << sh);
      lost = |(pn & mask);
      mant = shd[47:24];
      g    = shd[23];
      s    = (|shd[22:0]) | lost;
      inc  = g & (s | mant[0]);
      if (er >= 11'sd1) begin
         base = {1'b0, er[7:0] - 8'd1, 23'b0} + {8'b0, mant};
      end else begin
         base = {8'b0, mant};
      end
      sum = base + {31'b0, inc};
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         res = QNAN_BITS;
      end else if (a_inf || b_inf) begin
         res = {sr, INF_MAG};
      end else if (a_zero || b_zero) begin
         res = {sr, 31'd0};
      end else if (er >= 11'sd255 || sum[30:0] >= INF_MAG) begin
         res = {sr, INF_MAG};
      end else begin
         res = {sr, sum[30:0]};
      end
      return res;
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap, sx;
      logic [31:0] x, y, res, base, sum;
      logic [23:0] mx, my, mant;
      logic [7:0]  ex_e, ey_e, d, sl;
      logic [4:0]  dc, lz;
      logic [26:0] xe, ye, ysh, yal, mask, norm;
      logic [27:0] s_raw;
      logic [8:0]  eadj;
      logic        sticky, g, s, inc;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      swap   = a[30:0] < b[30:0];
      x      = swap ? b : a;
      y      = swap ? a : b;
      sx     = x[31];
      mx     = {x[30:23] != 8'd0, x[22:0]};
      my     = {y[30:23] != 8'd0, y[22:0]};
      ex_e   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey_e   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d      = ex_e - ey_e;
      dc     = (d > 8'd31) ? 5'd31 : d[4:0];
      xe     = {mx, 3'b0};
      ye     = {my, 3'b0};
      ysh    = ye >> dc;
      mask   = ~({27{1'b1}} << dc);
      sticky = |(ye & mask);
      yal    = {ysh[26:1], ysh[0] | sticky};
      if (x[31] == y[31]) begin
         s_raw = {1'b0, xe} + {1'b0, yal};
      end else begin
         s_raw = {1'b0, xe} - {1'b0, yal};
      end
      lz = clz27(s_raw[26:0]);
      if (s_raw[27]) begin
         norm = {s_raw[27:2], s_raw[1] | s_raw[0]};
         sl   = 8'd0;
         eadj = {1'b0, ex_e} + 9'd1;
      end else begin
         sl   = ({3'b0, lz} < ex_e) ? {3'b0, lz} : ex_e - 8'd1;
         norm = s_raw[26:0] << sl;
         eadj = {1'b0, ex_e} - {1'b0, sl};
      end
      mant = norm[26:3];
      g    = norm[2];
      s    = |norm[1:0];
      inc  = g & (s | mant[0]);
      base = {1'b0, 8'(eadj - 9'd1), 23'b0} + {8'b0, mant};
      sum  = base + {31'b0, inc};
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
         res = QNAN_BITS;
      end else if (a_inf) begin
         res = a;
      end else if (b_inf) begin
         res = b;
      end else if (a_zero && b_zero) begin
         res = {a[31] & b[31], 31'd0};
      end else if (a_zero) begin
         res = b;
      end else if (b_zero) begin
         res = a;
      end else if (s_raw == 28'd0) begin
         res = 32'd0;
      end else if (sum[30:0] >= INF_MAG) begin
         res = {sx, INF_MAG};
      end else begin
         res = {sx, sum[30:0]};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: sv/fast_exp_float32.sv
// fast_exp_float32: top level of the float32 exp approximation unit
// instantiates fef_front, fef_queue and fef_back; depends on fef_pkg
`default_nettype none

// Approximates exp(x) for one IEEE single-precision word per cycle. Each
// word is split as x = k*ln2 + y with k = floor(x/ln2), exp(y) comes from a
// degree-4 Horner polynomial, and the result is scaled by 2^k. Every add and
// multiply rounds to nearest-even on its own, with subnormals kept. A NaN
// operand returns the quiet NaN of the operand with status 3; k above 127
// returns +inf with status 1; k below -126 returns +0 with status 2; a
// final product that rounds to infinity also reports status 1. Throughput
// is one word per cycle while rsp_stall does not hold the back. A word
// passes two front stages (scale by 1/ln2, then floor and classify), the
// queue, eleven back stages (one float multiply or add each) and the
// result register. The queue of QUEUE_DEPTH words lets the front keep
// accepting while the back is held by rsp_stall.

module fast_exp_float32 #(
   parameter int QUEUE_DEPTH = fef_pkg::QUEUE_DEPTH_DEFAULT  // 2 or more
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // operand words
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_x_bits,
   // result words
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_result_bits,
   output logic [1:0]       rsp_range_status
);

   // front to queue
   logic                  q_push, q_full;
   fef_pkg::fef_item_type q_item;
   // queue to back
   logic                  q_pop, q_not_empty;
   fef_pkg::fef_item_type q_head;

   // front: scale by 1/ln2, floor, special-case detection
   fef_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_x_bits (req_x_bits),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   // decoupling buffer, lets the front run while the back is held
   fef_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (q_head)
   );

   // back: range reduction, polynomial, scale by 2^k, result register
   fef_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_bits  (rsp_result_bits),
      .rsp_range_status (rsp_range_status)
   );

endmodule

`default_nettype wire

FILE: sv/fef_front.sv
// fef_front: accepts operands, scales by 1/ln2 and classifies each word
// two register stages; pushes finished words into the queue
// depends on fef_pkg
`default_nettype none

module fef_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [31:0]          req_x_bits,
   input  wire logic                 q_full,
   output logic                      q_push,
   output fef_pkg::fef_item_type     q_item
);

   logic        f0_v_ff, f1_v_ff;
   logic [31:0] f0_x_ff, f1_x_ff, f1_t_ff;
   logic [31:0] f1_t_in;
   logic        f0_load, f1_load;

   // floor and classification signals
   logic [7:0]        t_exp;
   logic [23:0]       t_m24, frac_mask;
   logic [4:0]        shamt;
   logic [23:0]       ip24;
   logic [6:0]        ip;
   logic              frac_nz;
   logic signed [8:0] k;
   logic [6:0]        kmag;
   logic [2:0]        kpos;
   logic [23:0]       kshift;
   logic [31:0]       kf;
   logic              is_nan, is_ovf, is_unf;

   assign f1_load   = !f1_v_ff || !q_full;
   assign f0_load   = !f0_v_ff || f1_load;
   assign req_stall = !f0_load;
   assign q_push    = f1_v_ff && !q_full;
   assign f1_t_in   = fef_pkg::fmul(f0_x_ff, fef_pkg::INV_LN2_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_v_ff <= 1'b0;
         f1_v_ff <= 1'b0;
      end else begin
         if (f0_load) begin
            f0_v_ff <= req_valid;
         end
         if (f1_load) begin
            f1_v_ff <= f0_v_ff;
         end
      end
      if (f0_load && req_valid) begin
         f0_x_ff <= req_x_bits;
      end
      if (f1_load && f0_v_ff) begin
         f1_x_ff <= f0_x_ff;
         f1_t_ff <= f1_t_in;
      end
   end

   always_comb begin
      t_exp     = f1_t_ff[30:23];
      t_m24     = {1'b1, f1_t_ff[22:0]};
      shamt     = (t_exp >= 8'd127 && t_exp <= 8'd150) ? 5'(8'd150 - t_exp) : 5'd23;
      ip24      = t_m24 >> shamt;
      ip        = ip24[6:0];
      frac_mask = ~({24{1'b1}} << shamt);
      frac_nz   = |(t_m24 & frac_mask);
      if (t_exp < 8'd127) begin
         k = (f1_t_ff[31] && f1_t_ff[30:0] != 31'd0) ? -9'sd1 : 9'sd0;
      end else if (f1_t_ff[31]) begin
         k = -signed'({2'b0, ip} + {8'b0, frac_nz});
      end else begin
         k = signed'({2'b0, ip});
      end
      kmag = k[8] ? 7'(-k) : k[6:0];
      kpos = 3'd0;
      for (int i = 0; i < 7; i++) begin
         if (kmag[i]) begin
            kpos = 3'(i);
         end
      end
      kshift = {17'b0, kmag} << (5'd23 - {2'b0, kpos});
      if (kmag == 7'd0) begin
         kf = 32'd0;
      end else begin
         kf = {k[8], 8'd127 + {5'b0, kpos}, kshift[22:0]};
      end
      is_nan = (f1_x_ff[30:23] == 8'hFF) && (f1_x_ff[22:0] != 23'd0);
      is_ovf = !f1_t_ff[31] && (f1_t_ff[30:0] >= fef_pkg::T_OVF_MAG);
      is_unf = f1_t_ff[31] && (f1_t_ff[30:0] > fef_pkg::T_UNF_MAG);

      q_item.y       = f1_x_ff;
      q_item.p       = kf;
      q_item.e       = 8'(k + 9'sd127);
      q_item.byp     = is_nan || is_ovf || is_unf;
      priority if (is_nan) begin
         q_item.st      = fef_pkg::ST_NAN;
         q_item.byp_val = f1_x_ff | fef_pkg::QUIET_BIT;
      end else if (is_ovf) begin
         q_item.st      = fef_pkg::ST_OVERFLOW;
         q_item.byp_val = {1'b0, fef_pkg::INF_MAG};
      end else if (is_unf) begin
         q_item.st      = fef_pkg::ST_UNDERFLOW;
         q_item.byp_val = 32'd0;
      end else begin
         q_item.st      = fef_pkg::ST_NORMAL;
         q_item.byp_val = 32'd0;
      end
   end

endmodule

`default_nettype wire

FILE: sv/fef_queue.sv
// fef_queue: small first-in first-out buffer between front and back
// depends on fef_pkg for the word type
`default_nettype none

module fef_queue #(
   parameter int DEPTH = fef_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire fef_pkg::fef_item_type push_item,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       not_empty,
   output fef_pkg::fef_item_type      head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fef_pkg::fef_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: sv/fef_back.sv
// fef_back: range reduction, horner polynomial and scaling, one float op per stage
// elastic pipeline fed from the queue, ends in the result register
// depends on fef_pkg
`default_nettype none

module fef_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_not_empty,
   input  wire fef_pkg::fef_item_type q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [31:0]                rsp_result_bits,
   output logic [1:0]                 rsp_range_status
);

   typedef enum logic [3:0] {
      OP_KLN2, OP_REDUCE, OP_MUL_C4, OP_ADD_C3, OP_MUL_Y1, OP_ADD_C2,
      OP_MUL_Y2, OP_ADD_C1, OP_MUL_Y3, OP_ADD_C0, OP_SCALE
   } op_type;

   localparam int NUM_STAGES = 11;

   function automatic fef_pkg::fef_item_type apply_op(input op_type op,
                                                      input fef_pkg::fef_item_type it);
      fef_pkg::fef_item_type r;
      r = it;
      unique case (op)
         OP_KLN2:   r.p = fef_pkg::fmul(it.p, fef_pkg::LN2_BITS);
         OP_REDUCE: r.y = fef_pkg::fadd(it.y, {~it.p[31], it.p[30:0]});
         OP_MUL_C4: r.p = fef_pkg::fmul(it.y, fef_pkg::PC4_BITS);
         OP_ADD_C3: r.p = fef_pkg::fadd(it.p, fef_pkg::PC3_BITS);
         OP_MUL_Y1: r.p = fef_pkg::fmul(it.p, it.y);
         OP_ADD_C2: r.p = fef_pkg::fadd(it.p, fef_pkg::PC2_BITS);
         OP_MUL_Y2: r.p = fef_pkg::fmul(it.p, it.y);
         OP_ADD_C1: r.p = fef_pkg::fadd(it.p, fef_pkg::PC1_BITS);
         OP_MUL_Y3: r.p = fef_pkg::fmul(it.p, it.y);
         OP_ADD_C0: r.p = fef_pkg::fadd(it.p, fef_pkg::PC0_BITS);
         OP_SCALE:  r.p = fef_pkg::fmul(it.p, {1'b0, it.e, 23'b0});
         default:   r = it;
      endcase
      return r;
   endfunction

   logic                  v_ff    [NUM_STAGES];
   fef_pkg::fef_item_type data_ff [NUM_STAGES];
   fef_pkg::fef_item_type data_in [NUM_STAGES];
   logic                  load    [NUM_STAGES + 1];

   logic                  out_v_ff;
   logic [31:0]           out_res_ff, out_res_in;
   fef_pkg::fef_status_type out_st_ff, out_st_in;
   fef_pkg::fef_item_type last;

   assign load[NUM_STAGES] = !out_v_ff || !rsp_stall;
   assign q_pop            = q_not_empty && load[0];

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      logic                  src_v;
      fef_pkg::fef_item_type src;
      if (i == 0) begin : g_first
         assign src_v = q_not_empty;
         assign src   = q_head;
      end else begin : g_rest
         assign src_v = v_ff[i-1];
         assign src   = data_ff[i-1];
      end
      assign load[i]    = !v_ff[i] || load[i+1];
      assign data_in[i] = apply_op(op_type'(i), src);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (load[i]) begin
            v_ff[i] <= src_v;
         end
         if (load[i] && src_v) begin
            data_ff[i] <= data_in[i];
         end
      end
   end

   always_comb begin
      last = data_ff[NUM_STAGES-1];
      if (last.byp) begin
         out_res_in = last.byp_val;
         out_st_in  = last.st;
      end else begin
         out_res_in = last.p;
         out_st_in  = (last.p[30:0] == fef_pkg::INF_MAG) ? fef_pkg::ST_OVERFLOW
                                                          : fef_pkg::ST_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (load[NUM_STAGES]) begin
         out_v_ff <= v_ff[NUM_STAGES-1];
      end
      if (load[NUM_STAGES] && v_ff[NUM_STAGES-1]) begin
         out_res_ff <= out_res_in;
         out_st_ff  <= out_st_in;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_result_bits  = out_res_ff;
   assign rsp_range_status = out_st_ff;

endmodule

`default_nettype wire

FILE: sv/fef_checker.sv
// fef_checker: port-level checks for fast_exp_float32, bound to the top level
// depends on fef_pkg for status codes
`default_nettype none

module fef_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [31:0] req_x_bits,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_result_bits,
   input wire logic [1:0]  rsp_range_status
);

   // offered operand word stays put while stalled
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_x_bits))
      else $error("operand word changed while stalled");

   // held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits)
                                 && $stable(rsp_range_status))
      else $error("result word changed while stalled");

   // overflow status always carries an infinity
   a_ovf_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_status == fef_pkg::ST_OVERFLOW |->
         rsp_result_bits[30:0] == fef_pkg::INF_MAG)
      else $error("overflow status without infinity");

   // underflow status always carries +0
   a_unf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_status == fef_pkg::ST_UNDERFLOW |->
         rsp_result_bits == 32'd0)
      else $error("underflow status without zero");

   // nan status always carries a quiet nan
   a_nan_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_status == fef_pkg::ST_NAN |->
         rsp_result_bits[30:22] == 9'h1FF)
      else $error("nan status without quiet nan");

endmodule

bind fast_exp_float32 fef_checker u_fef_checker (.*);

`default_nettype wire

FILE: bench/fast_exp_float32_tb.sv
// fast_exp_float32_tb: self-checking bench for the float32 exp approximation unit
// bit-exact float32 predictor, directed table then random words; needs fef_pkg
// and fast_exp_float32
`timescale 1ns / 100ps

module fast_exp_float32_tb;

   localparam int     N_RANDOM    = 700;
   localparam int     CYCLE_LIMIT = 300000;
   localparam int     HOLD_CYCLES = 400;
   localparam int     DRAIN_WAIT  = 40;
   localparam [31:0]  F_INF       = 32'h7F800000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_x_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_result_bits;
   logic [1:0]  rsp_range_status;

   typedef struct {
      logic [31:0]             res;
      fef_pkg::fef_status_type st;
   } exp_word_type;

   // directed row: an operand, and optionally its result typed in by hand
   typedef struct {
      logic [31:0]             x;
      bit                      typed;
      logic [31:0]             res;
      fef_pkg::fef_status_type st;
   } stim_row_type;

   exp_word_type pending_q[$];
   int           n_errors;
   int           n_cycles;
   int           hold_req;

   fast_exp_float32 uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_bits       (req_x_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_bits  (rsp_result_bits),
      .rsp_range_status (rsp_range_status)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ------------------------------------------------------------------
   // float32 arithmetic for the predictor, round to nearest even,
   // subnormals kept
   // ------------------------------------------------------------------

   // round the exact value sgn * m * 2^e to a float32 pattern
   function automatic logic [31:0] fp_round(input logic sgn, input logic [63:0] m,
                                            input int e);
      int          p;
      int          be;
      int          sh;
      logic [63:0] q;
      logic        g;
      logic        st;
      longint      bits;
      if (m == 64'd0) return {sgn, 31'd0};
      p = 63;
      while (!m[p]) p--;
      // biased exponent, clamped so tiny values land on the subnormal grid
      be = p + e + 127;
      if (be < 1) be = 1;
      sh = be - 150 - e;
      if (sh > 64) begin
         q  = 64'd0;
         g  = 1'b0;
         st = 1'b1;
      end else if (sh > 0) begin
         q  = (sh == 64) ? 64'd0 : (m >> sh);
         g  = m[sh-1];
         st = (sh > 1) ? |(m & ((64'd1 << (sh - 1)) - 64'd1)) : 1'b0;
      end else begin
         q  = m << (-sh);
         g  = 1'b0;
         st = 1'b0;
      end
      if (g && (st || q[0])) q = q + 64'd1;
      // a carry out of the mantissa bumps the exponent by itself
      bits = (longint'(be - 1) <<< 23) + longint'(q);
      if (bits >= longint'(F_INF)) return {sgn, F_INF[30:0]};
      return {sgn, bits[30:0]};
   endfunction

   function automatic void fp_split(input logic [31:0] a, output logic [63:0] m,
                                    output int e);
      m = {40'd0, a[30:23] != 8'd0, a[22:0]};
      e = ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
   endfunction

   function automatic bit fp_is_inf(input logic [31:0] a);
      return a[30:0] == F_INF[30:0];
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sgn;
      logic [63:0] ma;
      logic [63:0] mb;
      int          ea;
      int          eb;
      sgn = a[31] ^ b[31];
      if (fp_is_inf(a) || fp_is_inf(b)) return {sgn, F_INF[30:0]};
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
      fp_split(a, ma, ea);
      fp_split(b, mb, eb);
      return fp_round(sgn, ma * mb, ea + eb);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] mt;
      int          ea;
      int          eb;
      int          et;
      int          d;
      logic        sa;
      logic        sb;
      logic        st;
      longint      acc;
      if (fp_is_inf(a)) return a;
      if (fp_is_inf(b)) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 31'd0) return b;
      if (b[30:0] == 31'd0) return a;
      fp_split(a, ma, ea);
      fp_split(b, mb, eb);
      sa = a[31];
      sb = b[31];
      if (ea < eb) begin
         mt = ma; ma = mb; mb = mt;
         et = ea; ea = eb; eb = et;
         st = sa; sa = sb; sb = st;
      end
      d = ea - eb;
      // far-below operand only matters as a sticky bit
      if (d > 36) begin
         mb = 64'd1;
         eb = ea - 36;
         d  = 36;
      end
      acc = (sa ? -longint'(ma << d) : longint'(ma << d))
          + (sb ? -longint'(mb) : longint'(mb));
      if (acc == 0) return 32'd0;
      if (acc < 0) return fp_round(1'b1, 64'(-acc), eb);
      return fp_round(1'b0, 64'(acc), eb);
   endfunction

   // floor of a float32 in [-126, 128)
   function automatic int fp_floor(input logic [31:0] t);
      int          ex;
      logic [23:0] mant;
      int          whole;
      bit          frac;
      ex = int'(t[30:23]) - 127;
      if (ex < 0) return (t[31] && t[30:0] != 31'd0) ? -1 : 0;
      mant  = {1'b1, t[22:0]};
      whole = int'(mant >> (23 - ex));
      frac  = |(mant & ((24'd1 << (23 - ex)) - 24'd1));
      if (!t[31]) return whole;
      return -whole - (frac ? 1 : 0);
   endfunction

   // expected result word for one operand
   function automatic exp_word_type exp_approx(input logic [31:0] x);
      exp_word_type w;
      logic [31:0]  t;
      logic [31:0]  kf;
      logic [31:0]  y;
      logic [31:0]  p;
      int           k;
      if (x[30:23] == 8'hFF && x[22:0] != 23'd0) begin
         w.res = x | fef_pkg::QUIET_BIT;
         w.st  = fef_pkg::ST_NAN;
         return w;
      end
      t = fp_mul(x, fef_pkg::INV_LN2_BITS);
      if (!t[31] && t[30:0] >= fef_pkg::T_OVF_MAG) begin
         w.res = F_INF;
         w.st  = fef_pkg::ST_OVERFLOW;
         return w;
      end
      if (t[31] && t[30:0] > fef_pkg::T_UNF_MAG) begin
         w.res = 32'd0;
         w.st  = fef_pkg::ST_UNDERFLOW;
         return w;
      end
      k  = fp_floor(t);
      kf = fp_round(k < 0, 64'(k < 0 ? -k : k), 0);
      y  = fp_add(x, fp_mul(kf, fef_pkg::LN2_BITS) ^ 32'h80000000);
      // horner, every step rounded on its own
      p = fp_mul(y, fef_pkg::PC4_BITS);
      p = fp_add(p, fef_pkg::PC3_BITS);
      p = fp_mul(p, y);
      p = fp_add(p, fef_pkg::PC2_BITS);
      p = fp_mul(p, y);
      p = fp_add(p, fef_pkg::PC1_BITS);
      p = fp_mul(p, y);
      p = fp_add(p, fef_pkg::PC0_BITS);
      w.res = fp_mul(p, {1'b0, 8'(k + fef_pkg::EXP_BIAS), 23'd0});
      w.st  = fp_is_inf(w.res) ? fef_pkg::ST_OVERFLOW : fef_pkg::ST_NORMAL;
      return w;
   endfunction

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   // random operand, weighted toward the interesting range
   function automatic logic [31:0] pick_operand();
      logic [31:0] x;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4:
            x = {1'($urandom), 8'($urandom_range(8'h70, 8'h85)), 23'($urandom)};
         5:    x = $urandom;
         6:    x = {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
         // near the overflow and underflow edges
         7:    x = {1'($urandom), 8'h85, 7'h2F + 7'($urandom_range(0, 3)), 16'($urandom)};
         8:    x = {1'($urandom), 8'hFF, ($urandom_range(0, 1) == 1) ? 23'($urandom) : 23'd0};
         default: x = {1'($urandom), 8'($urandom_range(8'h60, 8'h7F)), 23'($urandom)};
      endcase
      return x;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", n_cycles, what, got, want);
      n_errors++;
   endtask

   // offer one word and hold it until the block takes it
   task automatic send_word(input logic [31:0] x, input bit typed,
                            input exp_word_type typed_w);
      req_valid  = 1'b1;
      req_x_bits = x;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_q.push_back(typed ? typed_w : exp_approx(x));
      @(negedge clock);
   endtask

   // receiver stall pattern, plus the long hold-off on request
   initial begin : stall_driver
      int hold_seen;
      int hold_left;
      int mode;
      int mode_left;
      int phase;
      hold_seen = 0;
      hold_left = 0;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 100);
         end
         mode_left--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 9) < 3);
               2:       rsp_stall = (phase % 5) < 2;
               default: rsp_stall = ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      exp_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected word, result", rsp_result_bits, 32'd0);
         end else begin
            w = pending_q.pop_front();
            if (rsp_result_bits !== w.res)
               report_mismatch("result_bits", rsp_result_bits, w.res);
            if (rsp_range_status !== w.st)
               report_mismatch("range_status", {30'd0, rsp_range_status}, {30'd0, w.st});
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", n_cycles);
         $display("** fast_exp_float32: FAILED **");
         $finish;
      end
   end

   initial begin : main_seq
      stim_row_type table_rows[$];
      stim_row_type row;
      exp_word_type tw;
      int           sent;
      int           burst;
      int           gap;
      n_errors   = 0;
      n_cycles   = 0;
      hold_req   = 0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_x_bits = 32'd0;

      // directed rows; typed results only for the plain special cases
      table_rows = '{
         '{32'h7FC00000, 1, 32'h7FC00000, fef_pkg::ST_NAN},        // quiet nan
         '{32'h7F800001, 1, 32'h7FC00001, fef_pkg::ST_NAN},        // signaling nan
         '{32'hFFFFFFFF, 1, 32'hFFFFFFFF, fef_pkg::ST_NAN},        // negative nan
         '{32'h7F800000, 1, F_INF,        fef_pkg::ST_OVERFLOW},   // +inf
         '{32'hFF800000, 1, 32'h00000000, fef_pkg::ST_UNDERFLOW},  // -inf
         '{32'h7F7FFFFF, 1, F_INF,        fef_pkg::ST_OVERFLOW},   // largest finite
         '{32'hFF7FFFFF, 1, 32'h00000000, fef_pkg::ST_UNDERFLOW},  // most negative
         '{32'h42FE0000, 1, F_INF,        fef_pkg::ST_OVERFLOW},   // 127
         '{32'hC2B00000, 1, 32'h00000000, fef_pkg::ST_UNDERFLOW},  // -88
         '{32'h00000000, 0, 0, fef_pkg::ST_NORMAL},                // +0
         '{32'h80000000, 0, 0, fef_pkg::ST_NORMAL},                // -0
         '{32'h00000001, 0, 0, fef_pkg::ST_NORMAL},                // smallest subnormals
         '{32'h80000001, 0, 0, fef_pkg::ST_NORMAL},
         '{32'h3F800000, 0, 0, fef_pkg::ST_NORMAL},                // 1
         '{32'hBF800000, 0, 0, fef_pkg::ST_NORMAL},                // -1
         '{32'h3F000000, 0, 0, fef_pkg::ST_NORMAL},
         '{32'h41200000, 0, 0, fef_pkg::ST_NORMAL},
         '{32'hC1200000, 0, 0, fef_pkg::ST_NORMAL},
         '{32'h42B17218, 0, 0, fef_pkg::ST_NORMAL},                // near ln of max float
         '{32'h42B20000, 0, 0, fef_pkg::ST_NORMAL},                // just past the top
         '{32'hC2AE0000, 0, 0, fef_pkg::ST_NORMAL},                // k near the bottom
         '{32'hC2AEAC50, 0, 0, fef_pkg::ST_NORMAL},
         '{32'h3F317218, 0, 0, fef_pkg::ST_NORMAL}                 // ln2
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i]) begin
         row   = table_rows[i];
         tw.res = row.res;
         tw.st  = row.st;
         send_word(row.x, row.typed, tw);
      end

      // random words in bursts, with a long receiver hold-off and a full drain
      sent = 0;
      while (sent < N_RANDOM) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < N_RANDOM) begin
            if (sent == 200) hold_req++;
            if (sent == 450) begin
               req_valid = 1'b0;
               while (pending_q.size() != 0) @(negedge clock);
            end
            send_word(pick_operand(), 0, tw);
            sent++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid = 1'b0;

      while (pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (n_errors == 0) begin
         $display("** fast_exp_float32: PASSED **");
      end else begin
         $display("** fast_exp_float32: FAILED **");
      end
      $finish;
   end

endmodule
